// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, gated off during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, gated off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/grt_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid ray traversal package
// Constants, codes and types shared by the ray traversal RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package grt_pkg;

  // Map geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int TILE_W     = 6;
  localparam int ADDR_W     = 2 * TILE_W;
  localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  // Fixed point
  localparam int FRAC_BITS  = 10;
  localparam int DIR_FRAC   = 14;
  localparam int PER_W      = FRAC_BITS + DIR_FRAC + 1;
  localparam int DIST_W     = 32;
  localparam int CFG_W      = 7;

  // Item opcodes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } grt_op_t;

  // Configuration register indexes
  localparam logic [0:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [0:0] REG_MAP_HEIGHT = 1'b1;

  // Face normal codes
  localparam logic [2:0] NORM_NONE  = 3'd0;
  localparam logic [2:0] NORM_POS_X = 3'd1;
  localparam logic [2:0] NORM_NEG_X = 3'd2;
  localparam logic [2:0] NORM_POS_Y = 3'd3;
  localparam logic [2:0] NORM_NEG_Y = 3'd4;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_DIV_X,
    ST_DIV_Y,
    ST_FIRST,
    ST_STEP,
    ST_CHECK,
    ST_IMP_MUL,
    ST_IMP_ADD,
    ST_FINISH
  } grt_state_t;

endpackage

`default_nettype wire

// ===== src/grt_ifs.sv =====
// ----------------------------------------------------------------------------
// Grid ray traversal channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface grt_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [5:0]  tile_x;
  logic [5:0]  tile_y;
  logic        solid;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic [16:0] max_length;

  modport source (output valid, opcode, tile_x, tile_y, solid, start_x, start_y,
                  dir_x, dir_y, max_length, input ready);
  modport sink   (input valid, opcode, tile_x, tile_y, solid, start_x, start_y,
                  dir_x, dir_y, max_length, output ready);
endinterface

interface grt_out_if;
  logic        valid;
  logic        ready;
  logic        did_hit;
  logic [16:0] impact_dist;
  logic [16:0] impact_x;
  logic [16:0] impact_y;
  logic [2:0]  normal_code;

  modport source (output valid, did_hit, impact_dist, impact_x, impact_y, normal_code,
                  input ready);
  modport sink   (input valid, did_hit, impact_dist, impact_x, impact_y, normal_code,
                  output ready);
endinterface

interface grt_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] addr;
  logic [6:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== src/grt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module grt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/grid_ray_traversal_core.sv =====
// ----------------------------------------------------------------------------
// Grid ray traversal core
// Tile map ray caster: 2D DDA walk over a one-bit solid map held in RAM.
// ----------------------------------------------------------------------------
// After reset the core sweeps the 4096-entry map clear, one tile a cycle,
// and takes no item until the sweep is done (register writes are taken).
// A write item goes straight to the map RAM and the core stays idle. A cast
// looks up the start tile, forms the two per-crossing reciprocals one after
// the other on one shared bit-serial divider, sets up the first crossings,
// then reads the map RAM and checks it for each tile crossing walked, and
// on a hit forms the impact point before it hands over the result.
// The result sits in an output register, so the next item may enter while it
// waits to be taken.
`default_nettype none

`include "assert_macros.svh"

module grid_ray_traversal_core (
  input  wire logic  clk,
  input  wire logic  rst,
  grt_in_if.sink     in_ch,
  grt_out_if.source  out_ch,
  grt_cfg_if.sink    cfg_ch
);

  grt_pkg::grt_state_t state, state_next;

  logic [grt_pkg::ADDR_W-1:0] clr_addr;
  logic [grt_pkg::CFG_W-1:0]  map_w, map_h;

  // Latched cast
  logic [15:0]        sx, sy;
  logic signed [15:0] dx, dy;
  logic [16:0]        maxlen;
  logic signed [7:0]  tx, ty;
  logic               last_x;

  // Divider and crossing distances
  logic [16:0]               div_rem;
  logic [grt_pkg::PER_W-1:0] div_q;
  logic [4:0]                div_cnt;
  logic [grt_pkg::DIST_W-1:0] per_x, per_y, nx, ny;

  // Hit and result
  logic [16:0]        hit_dist;
  logic [2:0]         hit_norm;
  logic signed [33:0] prod_x, prod_y;
  logic               res_hit;
  logic [16:0]        res_dist, res_x, res_y;
  logic [2:0]         res_norm;

  // RAM ports
  logic                       ram_we;
  logic [grt_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic                       ram_wdata, ram_rdata;

  logic in_acc, out_free;

  assign in_ch.ready  = (state == grt_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_ch.valid || out_ch.ready;

  // Effective map size
  logic [grt_pkg::CFG_W-1:0] w_eff, h_eff;
  assign w_eff = (map_w > 7'(grt_pkg::MAX_WIDTH))  ? 7'(grt_pkg::MAX_WIDTH)  : map_w;
  assign h_eff = (map_h > 7'(grt_pkg::MAX_HEIGHT)) ? 7'(grt_pkg::MAX_HEIGHT) : map_h;

  // Current tile blocks: outside the map or solid
  logic blocks;
  assign blocks = tx[7] || ty[7] || (tx[6:0] >= w_eff) || (ty[6:0] >= h_eff) || ram_rdata;

  // Direction magnitudes and start gaps
  logic [16:0] mag_x, mag_y, div_mag;
  logic [10:0] gap_x, gap_y;
  assign mag_x = dx[15] ? (17'd0 - {1'b1, dx}) : {1'b0, dx};
  assign mag_y = dy[15] ? (17'd0 - {1'b1, dy}) : {1'b0, dy};
  assign gap_x = dx[15] ? {1'b0, sx[9:0]} : (11'd1024 - {1'b0, sx[9:0]});
  assign gap_y = dy[15] ? {1'b0, sy[9:0]} : (11'd1024 - {1'b0, sy[9:0]});
  assign div_mag = (state == grt_pkg::ST_DIV_X) ? mag_x : mag_y;

  // One restoring divide step of 2^24 by the magnitude
  logic [16:0] div_trial;
  logic        div_ge;
  logic [grt_pkg::PER_W-1:0] div_q_next;
  logic [grt_pkg::DIST_W-1:0] per_done;
  assign div_trial  = {div_rem[15:0], (div_cnt == 5'd24)};
  assign div_ge     = (div_trial >= div_mag);
  assign div_q_next = {div_q[grt_pkg::PER_W-2:0], div_ge};
  assign per_done   = (div_mag == 17'd0) ? '1 : {7'd0, div_q_next};

  // First crossings
  logic [35:0] fprod_x, fprod_y;
  assign fprod_x = {25'd0, gap_x} * {11'd0, per_x[grt_pkg::PER_W-1:0]};
  assign fprod_y = {25'd0, gap_y} * {11'd0, per_y[grt_pkg::PER_W-1:0]};

  // Crossing choice and next tile
  logic                       take_x, over;
  logic [grt_pkg::DIST_W-1:0] n_sel;
  logic signed [7:0]          tx_step, ty_step;
  assign take_x  = (nx < ny);
  assign n_sel   = take_x ? nx : ny;
  assign over    = (n_sel > {15'd0, maxlen});
  assign tx_step = take_x ? (tx + (dx[15] ? -8'sd1 : 8'sd1)) : tx;
  assign ty_step = take_x ? ty : (ty + (dy[15] ? -8'sd1 : 8'sd1));

  // Saturating crossing advance
  logic [32:0] sum_x, sum_y;
  assign sum_x = {1'b0, nx} + {1'b0, per_x};
  assign sum_y = {1'b0, ny} + {1'b0, per_y};

  // Impact point: round product, add start, saturate
  logic signed [33:0] rnd_x, rnd_y;
  logic signed [21:0] pos_x, pos_y;
  logic [16:0]        imp_x, imp_y;
  assign rnd_x = prod_x + 34'sd8192;
  assign rnd_y = prod_y + 34'sd8192;
  assign pos_x = $signed({6'd0, sx}) + $signed({{2{rnd_x[33]}}, rnd_x[33:14]});
  assign pos_y = $signed({6'd0, sy}) + $signed({{2{rnd_y[33]}}, rnd_y[33:14]});
  assign imp_x = pos_x[21] ? 17'd0 : ((pos_x[20:17] != 4'd0) ? '1 : pos_x[16:0]);
  assign imp_y = pos_y[21] ? 17'd0 : ((pos_y[20:17] != 4'd0) ? '1 : pos_y[16:0]);

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = 1'b0;
    ram_raddr = {ty_step[5:0], tx_step[5:0]};
    if (state == grt_pkg::ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (in_acc && in_ch.opcode == grt_pkg::OP_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = {in_ch.tile_y, in_ch.tile_x};
      ram_wdata = in_ch.solid;
    end
    if (state == grt_pkg::ST_IDLE) begin
      ram_raddr = {in_ch.start_y[15:10], in_ch.start_x[15:10]};
    end
  end

  grt_ram #(
    .WIDTH (1),
    .DEPTH (grt_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      grt_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = grt_pkg::ST_IDLE;
      end
      grt_pkg::ST_IDLE: begin
        if (in_acc && in_ch.opcode == grt_pkg::OP_CAST) state_next = grt_pkg::ST_START;
      end
      grt_pkg::ST_START: begin
        state_next = blocks ? grt_pkg::ST_FINISH : grt_pkg::ST_DIV_X;
      end
      grt_pkg::ST_DIV_X: begin
        if (div_cnt == 5'd0) state_next = grt_pkg::ST_DIV_Y;
      end
      grt_pkg::ST_DIV_Y: begin
        if (div_cnt == 5'd0) state_next = grt_pkg::ST_FIRST;
      end
      grt_pkg::ST_FIRST: state_next = grt_pkg::ST_STEP;
      grt_pkg::ST_STEP: begin
        state_next = over ? grt_pkg::ST_FINISH : grt_pkg::ST_CHECK;
      end
      grt_pkg::ST_CHECK: begin
        state_next = blocks ? grt_pkg::ST_IMP_MUL : grt_pkg::ST_STEP;
      end
      grt_pkg::ST_IMP_MUL: state_next = grt_pkg::ST_IMP_ADD;
      grt_pkg::ST_IMP_ADD: state_next = grt_pkg::ST_FINISH;
      grt_pkg::ST_FINISH: begin
        if (out_free) state_next = grt_pkg::ST_IDLE;
      end
      default: state_next = grt_pkg::ST_CLEAR;
    endcase
  end

  // Control registers: clear sweep, map size, result handover
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      map_w        <= 7'd64;
      map_h        <= 7'd64;
      out_ch.valid <= 1'b0;
    end else begin
      if (state == grt_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.addr == grt_pkg::REG_MAP_WIDTH) map_w <= cfg_ch.data;
        if (cfg_ch.addr == grt_pkg::REG_MAP_HEIGHT) map_h <= cfg_ch.data;
      end
      if (state == grt_pkg::ST_FINISH && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      grt_pkg::ST_IDLE: begin
        if (in_acc) begin
          sx     <= in_ch.start_x;
          sy     <= in_ch.start_y;
          dx     <= in_ch.dir_x;
          dy     <= in_ch.dir_y;
          maxlen <= in_ch.max_length;
          tx     <= $signed({2'b00, in_ch.start_x[15:10]});
          ty     <= $signed({2'b00, in_ch.start_y[15:10]});
        end
      end
      grt_pkg::ST_START: begin
        // Start inside a blocking tile
        res_hit  <= 1'b1;
        res_dist <= 17'd0;
        res_x    <= {1'b0, sx};
        res_y    <= {1'b0, sy};
        res_norm <= grt_pkg::NORM_NONE;
        div_rem  <= '0;
        div_q    <= '0;
        div_cnt  <= 5'd24;
      end
      grt_pkg::ST_DIV_X, grt_pkg::ST_DIV_Y: begin
        div_rem <= div_ge ? (div_trial - div_mag) : div_trial;
        div_q   <= div_q_next;
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == 5'd0) begin
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= 5'd24;
          if (state == grt_pkg::ST_DIV_X) per_x <= per_done;
          else per_y <= per_done;
        end
      end
      grt_pkg::ST_FIRST: begin
        nx <= (mag_x == 17'd0) ? '1 : {6'd0, fprod_x[35:10]};
        ny <= (mag_y == 17'd0) ? '1 : {6'd0, fprod_y[35:10]};
      end
      grt_pkg::ST_STEP: begin
        // Miss result, used only when the crossing lies beyond the limit
        res_hit  <= 1'b0;
        res_dist <= 17'd0;
        res_x    <= 17'd0;
        res_y    <= 17'd0;
        res_norm <= grt_pkg::NORM_NONE;
        tx       <= tx_step;
        ty       <= ty_step;
        last_x   <= take_x;
      end
      grt_pkg::ST_CHECK: begin
        if (last_x) begin
          hit_dist <= nx[16:0];
          hit_norm <= dx[15] ? grt_pkg::NORM_POS_X : grt_pkg::NORM_NEG_X;
          if (!blocks) nx <= sum_x[32] ? '1 : sum_x[31:0];
        end else begin
          hit_dist <= ny[16:0];
          hit_norm <= dy[15] ? grt_pkg::NORM_POS_Y : grt_pkg::NORM_NEG_Y;
          if (!blocks) ny <= sum_y[32] ? '1 : sum_y[31:0];
        end
      end
      grt_pkg::ST_IMP_MUL: begin
        prod_x <= $signed({{18{dx[15]}}, dx}) * $signed({17'd0, hit_dist});
        prod_y <= $signed({{18{dy[15]}}, dy}) * $signed({17'd0, hit_dist});
      end
      grt_pkg::ST_IMP_ADD: begin
        res_hit  <= 1'b1;
        res_dist <= hit_dist;
        res_x    <= imp_x;
        res_y    <= imp_y;
        res_norm <= hit_norm;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == grt_pkg::ST_FINISH && out_free) begin
      out_ch.did_hit     <= res_hit;
      out_ch.impact_dist <= res_dist;
      out_ch.impact_x    <= res_x;
      out_ch.impact_y    <= res_y;
      out_ch.normal_code <= res_norm;
    end
  end

  `ASSERT_IMPLY(a_miss_zero, clk, rst, out_ch.valid && !out_ch.did_hit, out_ch.impact_dist == 17'd0 && out_ch.impact_x == 17'd0 && out_ch.normal_code == grt_pkg::NORM_NONE, "miss result carries nonzero fields")
  `ASSERT_IMPLY(a_tile_range, clk, rst, state == grt_pkg::ST_CHECK, tx >= -8'sd1 && tx <= 8'sd64 && ty >= -8'sd1 && ty <= 8'sd64, "walked tile left the map border")
  `ASSERT_IMPLY(a_no_write_busy, clk, rst, state != grt_pkg::ST_IDLE && state != grt_pkg::ST_CLEAR, !ram_we, "map written during a cast")

endmodule

`default_nettype wire

// ===== tb/grt_tb_ifs.sv =====
// ----------------------------------------------------------------------------
// Ray traversal testbench channel note
// The RTL channel interfaces are used as they stand; this file holds shared
// testbench types for the ray traversal checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package grt_tb_pkg;
  import grt_pkg::*;

  // One input item as the driver offers it
  typedef struct packed {
    grt_op_t            opcode;
    logic [5:0]         tile_x;
    logic [5:0]         tile_y;
    logic               solid;
    logic [15:0]        start_x;
    logic [15:0]        start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [16:0]        max_length;
  } ray_item_t;

  // One cast result
  typedef struct packed {
    logic        did_hit;
    logic [16:0] impact_dist;
    logic [16:0] impact_x;
    logic [16:0] impact_y;
    logic [2:0]  normal_code;
  } ray_hit_t;
endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Ray traversal core testbench
// Drives tile writes and ray casts with bursty traffic and a stalling result
// side, predicts every cast with a behavioral DDA walk and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import grt_pkg::*;
  import grt_tb_pkg::*;

  localparam longint CAP32 = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   failed = 1'b0;
  int   cycle_count = 0;

  grt_in_if  in_ch();
  grt_out_if out_ch();
  grt_cfg_if cfg_ch();

  grid_ray_traversal_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  bit       tiles [MAX_WIDTH*MAX_HEIGHT];
  int       cols = 64;
  int       rows = 64;
  ray_item_t pending_items[$];
  ray_hit_t  expected_hits[$];

  // Traffic control
  bit hold_sender = 1'b0;
  bit long_stall = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  // Queue one item for the driver
  function automatic void add_pending(ray_item_t it);
    pending_items = {pending_items, it};
  endfunction

  // Queue one expected result for the monitor
  function automatic void add_expected(ray_hit_t r);
    expected_hits = {expected_hits, r};
  endfunction

  function automatic bit is_blocked(int x, int y);
    int w, h;
    w = (cols > MAX_WIDTH) ? MAX_WIDTH : cols;
    h = (rows > MAX_HEIGHT) ? MAX_HEIGHT : rows;
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b1;
    return tiles[y*MAX_WIDTH + x];
  endfunction

  function automatic void crossing_setup(int start, int dir, output longint per,
                                         output longint first);
    longint mag, frac, gap;
    mag = (dir < 0) ? -dir : dir;
    frac = start & 1023;
    gap = (dir < 0) ? frac : 1024 - frac;
    if (mag == 0) begin
      per = CAP32;
      first = CAP32;
    end else begin
      per = (64'd1 << 24) / mag;
      if (per > CAP32) per = CAP32;
      first = (gap * per) >>> 10;
      if (first > CAP32) first = CAP32;
    end
  endfunction

  function automatic logic [16:0] impact_point(int start, int dir, longint len);
    longint prod, q, p;
    prod = longint'(dir) * len;
    q = (prod + (64'sd1 <<< 13)) >>> 14;
    p = start + q;
    if (p < 0) return 17'd0;
    if (p > 131071) return 17'h1FFFF;
    return p[16:0];
  endfunction

  // Apply one accepted item to the prediction
  function automatic void predict_item(ray_item_t it);
    ray_hit_t r;
    int sx, sy, dx, dy, tx, ty, stx, sty;
    longint perx, pery, nx, ny, hit_len, lim;
    logic [2:0] nrm;
    bit hit;
    if (it.opcode == OP_WRITE) begin
      tiles[it.tile_y*MAX_WIDTH + it.tile_x] = it.solid;
      return;
    end
    sx = it.start_x; sy = it.start_y; dx = it.dir_x; dy = it.dir_y;
    lim = it.max_length;
    tx = sx >> 10; ty = sy >> 10;
    r = '0;
    if (is_blocked(tx, ty)) begin
      r.did_hit = 1'b1;
      r.impact_x = 17'(sx);
      r.impact_y = 17'(sy);
      r.normal_code = NORM_NONE;
      add_expected(r);
      return;
    end
    crossing_setup(sx, dx, perx, nx);
    crossing_setup(sy, dy, pery, ny);
    stx = (dx < 0) ? -1 : 1;
    sty = (dy < 0) ? -1 : 1;
    hit = 1'b0;
    forever begin
      if (nx < ny) begin
        if (nx > lim) break;
        tx += stx;
        if (is_blocked(tx, ty)) begin
          hit = 1'b1; hit_len = nx; nrm = (stx < 0) ? NORM_POS_X : NORM_NEG_X;
          break;
        end
        nx = (nx + perx > CAP32) ? CAP32 : nx + perx;
      end else begin
        if (ny > lim) break;
        ty += sty;
        if (is_blocked(tx, ty)) begin
          hit = 1'b1; hit_len = ny; nrm = (sty < 0) ? NORM_POS_Y : NORM_NEG_Y;
          break;
        end
        ny = (ny + pery > CAP32) ? CAP32 : ny + pery;
      end
    end
    if (hit) begin
      r.did_hit = 1'b1;
      r.impact_dist = hit_len[16:0];
      r.impact_x = impact_point(sx, dx, hit_len);
      r.impact_y = impact_point(sy, dy, hit_len);
      r.normal_code = nrm;
    end
    add_expected(r);
  endfunction

  // Driver: bursts with random gaps, holds while paused
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_item(pending_items.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_sender) begin
        in_ch.valid <= 1'b1;
        {in_ch.opcode, in_ch.tile_x, in_ch.tile_y, in_ch.solid, in_ch.start_x,
         in_ch.start_y, in_ch.dir_x, in_ch.dir_y, in_ch.max_length}
          <= pending_items[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern and the long hold-off
  always @(posedge clk) begin
    if (rst || long_stall) out_ch.ready <= 1'b0;
    else out_ch.ready <= (cycle_count % 1000 < 300) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    ray_hit_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.did_hit, out_ch.impact_dist, out_ch.impact_x, out_ch.impact_y,
             out_ch.normal_code};
      if (expected_hits.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1'b1;
      end else begin
        want = expected_hits.pop_front();
        if (got.did_hit !== want.did_hit) begin
          $error("did_hit exp %0d got %0d", want.did_hit, got.did_hit); failed = 1'b1;
        end
        if (got.impact_dist !== want.impact_dist) begin
          $error("impact_dist exp %0d got %0d", want.impact_dist, got.impact_dist);
          failed = 1'b1;
        end
        if (got.impact_x !== want.impact_x) begin
          $error("impact_x exp %0d got %0d", want.impact_x, got.impact_x); failed = 1'b1;
        end
        if (got.impact_y !== want.impact_y) begin
          $error("impact_y exp %0d got %0d", want.impact_y, got.impact_y); failed = 1'b1;
        end
        if (got.normal_code !== want.normal_code) begin
          $error("normal_code exp %0d got %0d", want.normal_code, got.normal_code);
          failed = 1'b1;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    if (cycle_count > 3_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic ray_item_t tile_write(int x, int y, bit s);
    ray_item_t it;
    it = '0;
    it.opcode = OP_WRITE; it.tile_x = 6'(x); it.tile_y = 6'(y); it.solid = s;
    return it;
  endfunction

  function automatic ray_item_t ray_cast(int sx, int sy, int dx, int dy, int len);
    ray_item_t it;
    it.opcode = OP_CAST;
    it.tile_x = 6'($urandom); it.tile_y = 6'($urandom); it.solid = 1'($urandom);
    it.start_x = 16'(sx); it.start_y = 16'(sy);
    it.dir_x = 16'(dx); it.dir_y = 16'(dy); it.max_length = 17'(len);
    return it;
  endfunction

  function automatic int unit_dir();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 16384;
    if (r == 2) return -16384;
    return $signed($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic ray_item_t random_item(int span);
    if ($urandom_range(0, 2) == 0)
      return tile_write($urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 15) == 0)
      return ray_cast($urandom, $urandom, $signed(16'($urandom)), $signed(16'($urandom)),
                      $urandom_range(0, 131071));
    return ray_cast($urandom_range(0, span*1024 - 1), $urandom_range(0, span*1024 - 1),
                    unit_dir(), unit_dir(),
                    ($urandom_range(0, 7) == 0) ? 131071 : $urandom_range(0, 12000));
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= 7'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MAP_WIDTH) cols = val; else rows = val;
  endtask

  initial begin
    int settings[5][2];
    in_ch.valid = 1'b0;
    {in_ch.opcode, in_ch.tile_x, in_ch.tile_y, in_ch.solid, in_ch.start_x,
     in_ch.start_y, in_ch.dir_x, in_ch.dir_y, in_ch.max_length} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_MAP_WIDTH;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, inside-solid start, outside map, axis rays, ties
    add_pending(ray_cast(0, 0, 16384, 0, 131071));
    add_pending(ray_cast(32*1024+512, 32*1024+512, 0, 0, 131071));
    add_pending(ray_cast(32*1024+512, 32*1024+512, -16384, 0, 5000));
    add_pending(ray_cast(32*1024+512, 32*1024+512, 0, -16384, 131071));
    add_pending(ray_cast(10*1024+512, 10*1024+512, 11585, 11585, 131071));
    add_pending(ray_cast(65535, 65535, 16384, 16384, 131071));
    add_pending(ray_cast(1000, 1000, -16384, -16384, 0));
    add_pending(tile_write(33, 32, 1'b1));
    add_pending(tile_write(63, 63, 1'b1));
    add_pending(ray_cast(32*1024+512, 32*1024+512, 16384, 0, 131071));
    add_pending(ray_cast(33*1024+7, 32*1024+9, 100, -100, 131071));
    add_pending(ray_cast(62*1024, 62*1024+1023, 16384, 16384, 131071));
    add_pending(ray_cast(5*1024, 5*1024, -32768, 32767, 131071));
    add_pending(ray_cast(20*1024, 20*1024, 1, -1, 131071));
    add_pending(tile_write(33, 32, 1'b0));
    add_pending(tile_write(63, 63, 1'b0));
    add_pending(ray_cast(32*1024+512, 32*1024+512, 16384, 0, 131071));

    // Register settings, extremes included; long output stall in phase one
    settings = '{'{64, 64}, '{1, 1}, '{127, 100}, '{0, 5}, '{9, 64}};
    for (int ph = 0; ph < 5; ph++) begin
      int span;
      wait_drained();
      write_reg(REG_MAP_WIDTH, settings[ph][0]);
      write_reg(REG_MAP_HEIGHT, settings[ph][1]);
      span = (ph == 0) ? 64 : ($urandom_range(0, 1) ? 12 : 64);
      if (ph == 1) begin
        long_stall = 1'b1;
        repeat (30) add_pending(random_item(span));
        repeat (3000) @(posedge clk);
        long_stall = 1'b0;
      end
      if (ph == 2) begin
        // Pause the sender until everything queued has come back
        hold_sender = 1'b1;
        while (in_ch.valid || expected_hits.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      repeat (385) add_pending(random_item(span));
    end
    wait_drained();
    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/grt_pkg.sv
src/grt_ifs.sv
src/grt_ram.sv
src/grid_ray_traversal_core.sv
tb/grt_tb_ifs.sv
tb/tb_top.sv
